// ----- rtl/modular_inverse_ext_euclid_macros.svh -----
// Assertion macros for the modular inverse checker.
`ifndef MODULAR_INVERSE_EXT_EUCLID_MACROS_SVH
`define MODULAR_INVERSE_EXT_EUCLID_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define MIE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mie assertion failed");

// Next-cycle implication, masked while reset is high.
`define MIE_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mie assertion failed");

// Next-cycle implication that is also checked across reset.
`define MIE_ASSERT_NXT_ALL(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mie assertion failed");

`endif

// ----- rtl/mie_pkg.sv -----
// Package: widths, codes, state and result types of the modular inverse block.
`default_nettype none

package mie_pkg;

  localparam int VALUE_BITS = 48;
  localparam int MOD_BITS   = 31;
  localparam int DATA_BITS  = 32;
  localparam int ADDR_BITS  = 3;

  // Coefficient, subtractor, shift and bit counter widths
  localparam int COEF_BITS  = MOD_BITS + 1;
  localparam int ALU_BITS   = MOD_BITS + 2;
  localparam int SHIFT_BITS = $clog2(MOD_BITS);
  localparam int CNT_BITS   = $clog2(VALUE_BITS);

  localparam logic [MOD_BITS-1:0] MODULUS_RESET = MOD_BITS'(64'd1000000007);

  // Register index as decoded from paddr[2]
  localparam logic REG_MODULUS_IDX = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_CHECK,
    ST_ALIGN,
    ST_SUB,
    ST_FINAL
  } mie_state_t;

  typedef struct packed {
    logic [MOD_BITS-1:0] inverse;
    logic [MOD_BITS-1:0] common_divisor;
    logic                has_inverse;
  } mie_result_t;

endpackage

`default_nettype wire

// ----- rtl/mie_channels.sv -----
// Valid/ready channel interfaces for operand and result beats.
`default_nettype none

interface mie_in_if
  import mie_pkg::*;
  ;
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
  modport mon    (input valid, input value, input ready);
endinterface

interface mie_out_if
  import mie_pkg::*;
  ;
  logic                valid;
  logic                ready;
  logic [MOD_BITS-1:0] inverse;
  logic [MOD_BITS-1:0] common_divisor;
  logic                has_inverse;

  modport source (output valid, output inverse, output common_divisor,
                  output has_inverse, input ready);
  modport sink   (input valid, input inverse, input common_divisor,
                  input has_inverse, output ready);
  modport mon    (input valid, input inverse, input common_divisor,
                  input has_inverse, input ready);
endinterface

`default_nettype wire

// ----- rtl/mie_engine.sv -----
// Sequencer and shared subtractor that run reduction and extended Euclid.
`default_nettype none

module mie_engine
  import mie_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       ready,
  input  wire logic [VALUE_BITS-1:0] value,
  input  wire logic [MOD_BITS-1:0]   modulus,
  output logic                       res_valid,
  input  wire logic                  res_ready,
  output mie_result_t                res
);

  mie_state_t state, state_next;

  logic [VALUE_BITS-1:0] vbuf;
  logic [CNT_BITS-1:0]   cnt;
  logic [MOD_BITS-1:0]   u;
  logic [MOD_BITS-1:0]   v;
  logic [COEF_BITS-1:0]  pu;
  logic [COEF_BITS-1:0]  pv;
  logic [MOD_BITS-1:0]   d;
  logic [COEF_BITS-1:0]  e;
  logic [SHIFT_BITS-1:0] k;
  logic                  pn;
  logic                  cn;

  logic [ALU_BITS-1:0] alu_a;
  logic [ALU_BITS-1:0] alu_b;
  logic [ALU_BITS:0]   alu_diff;
  logic                borrow;
  logic [MOD_BITS:0]   shifted_rem;
  logic [MOD_BITS-1:0] nu;
  logic [COEF_BITS-1:0] npu;
  logic                has;
  logic                mag_below;

  // Bring in the next operand bit for the restoring reduction
  assign shifted_rem = {v, vbuf[VALUE_BITS-1]};

  // Route operands into the one shared subtractor
  always_comb begin
    unique case (state)
      ST_REDUCE: begin
        alu_a = ALU_BITS'(shifted_rem);
        alu_b = ALU_BITS'(modulus);
      end
      ST_ALIGN: begin
        alu_a = ALU_BITS'(u);
        alu_b = ALU_BITS'({d, 1'b0});
      end
      ST_SUB: begin
        alu_a = ALU_BITS'(u);
        alu_b = ALU_BITS'(d);
      end
      ST_FINAL: begin
        alu_a = ALU_BITS'(modulus);
        alu_b = ALU_BITS'(pu);
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
  assign borrow   = alu_diff[ALU_BITS];

  // Partial division step: keep or take the subtraction, add the scaled coefficient
  assign nu  = borrow ? u : alu_diff[MOD_BITS-1:0];
  assign npu = borrow ? pu : pu + e;

  // Result: gcd is the last nonzero remainder, coefficient folded into range
  assign has       = (u == MOD_BITS'(1));
  assign mag_below = !borrow && (alu_diff[MOD_BITS-1:0] != '0);

  always_comb begin
    res.common_divisor = u;
    res.has_inverse    = has;
    if (has && mag_below) begin
      res.inverse = pn ? alu_diff[MOD_BITS-1:0] : pu[MOD_BITS-1:0];
    end else begin
      res.inverse = '0;
    end
  end

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence: reduce, then each Euclid step as test, align then shift-subtract
  always_comb begin
    state_next = state;
    ready      = 1'b0;
    res_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        ready = 1'b1;
        if (start) begin
          state_next = (modulus == '0) ? ST_FINAL : ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (cnt == '0) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = (v == '0) ? ST_FINAL : ST_ALIGN;
      end
      ST_ALIGN: begin
        if (borrow) begin
          state_next = ST_SUB;
        end
      end
      ST_SUB: begin
        if (k == '0) begin
          state_next = ST_CHECK;
        end
      end
      ST_FINAL: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Advance the datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        vbuf <= value;
        cnt  <= CNT_BITS'(VALUE_BITS - 1);
        v    <= '0;
        u    <= '0;
        pu   <= '0;
        pn   <= 1'b0;
      end
      ST_REDUCE: begin
        vbuf <= {vbuf[VALUE_BITS-2:0], 1'b0};
        cnt  <= cnt - CNT_BITS'(1);
        v    <= borrow ? shifted_rem[MOD_BITS-1:0] : alu_diff[MOD_BITS-1:0];
        if (cnt == '0) begin
          u  <= modulus;
          pu <= '0;
          pv <= COEF_BITS'(1);
          pn <= 1'b0;
          cn <= 1'b0;
        end
      end
      ST_CHECK: begin
        d <= v;
        e <= pv;
        k <= '0;
      end
      ST_ALIGN: begin
        if (!borrow) begin
          d <= {d[MOD_BITS-2:0], 1'b0};
          e <= {e[COEF_BITS-2:0], 1'b0};
          k <= k + SHIFT_BITS'(1);
        end
      end
      ST_SUB: begin
        if (k == '0) begin
          // Step done: shift the remainder and coefficient pairs
          u  <= v;
          v  <= nu;
          pu <= pv;
          pv <= npu;
          pn <= cn;
          cn <= !cn;
        end else begin
          u  <= nu;
          pu <= npu;
          d  <= {1'b0, d[MOD_BITS-1:1]};
          e  <= {1'b0, e[COEF_BITS-1:1]};
          k  <= k - SHIFT_BITS'(1);
        end
      end
      ST_FINAL: begin
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/modular_inverse_ext_euclid.sv -----
// Modular inverse by the extended Euclidean algorithm, one operand at a time.
// Each operand beat is first reduced modulo the modulus register by restoring
// division, one operand bit per cycle, then the extended Euclidean algorithm
// runs with every quotient formed by shift-and-subtract on one shared
// subtractor: each Euclid step tests the remainder, aligns the divisor by
// shifting it left, then subtracts one quotient bit at a time from the top.
// An operand that reduces to zero goes from the test straight to the result;
// a zero modulus skips the reduction and the Euclid steps. The operand channel
// is not ready while an item is in work; a finished result sits in an output
// register, so the next operand is taken while it waits. The modulus register
// sits at byte address 0 and must only be written while the block is idle.
`default_nettype none

module modular_inverse_ext_euclid
  import mie_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_BITS-1:0] paddr,
  input  wire logic [DATA_BITS-1:0] pwdata,
  output logic      [DATA_BITS-1:0] prdata,
  output logic                      pready,
  mie_in_if.sink                    request,
  mie_out_if.source                 result
);

  logic [MOD_BITS-1:0] modulus;
  logic                res_valid;
  logic                res_ready;
  mie_result_t         res;
  logic                out_valid;
  mie_result_t         out_res;

  // Configuration register, written in the access phase
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_MODULUS_IDX)) begin
      modulus <= pwdata[MOD_BITS-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_MODULUS_IDX) ? DATA_BITS'(modulus) : '0;

  mie_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (request.valid),
    .ready     (request.ready),
    .value     (request.value),
    .modulus   (modulus),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: load a finished result when the slot is free or draining
  assign res_ready = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign result.valid          = out_valid;
  assign result.inverse        = out_res.inverse;
  assign result.common_divisor = out_res.common_divisor;
  assign result.has_inverse    = out_res.has_inverse;

endmodule

`default_nettype wire

// ----- rtl/mie_checker.sv -----
// Port-level assertions for the modular inverse block, bound to its top level.
`default_nettype none
`include "modular_inverse_ext_euclid_macros.svh"

module mie_checker
  import mie_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [MOD_BITS-1:0] out_inverse,
  input wire logic [MOD_BITS-1:0] out_common_divisor,
  input wire logic                out_has_inverse
);

  // A result beat held back stays offered
  `MIE_ASSERT_NXT(a_result_hold, clk, rst, out_valid && !out_ready, out_valid)

  // Reset empties the output register
  `MIE_ASSERT_NXT_ALL(a_reset_empty, clk, rst, !out_valid)

  // An accepted operand keeps the engine busy on the next cycle
  `MIE_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)

  // An inverse is only reported with a gcd of one
  `MIE_ASSERT_IMP(a_inverse_gcd, clk, rst, out_valid && out_has_inverse, out_common_divisor == MOD_BITS'(1))

  // No inverse means a zero inverse field
  `MIE_ASSERT_IMP(a_no_inverse_zero, clk, rst, out_valid && !out_has_inverse, out_inverse == '0)

endmodule

bind modular_inverse_ext_euclid mie_checker u_mie_checker (
  .clk                (clk),
  .rst                (rst),
  .in_valid           (request.valid),
  .in_ready           (request.ready),
  .out_valid          (result.valid),
  .out_ready          (result.ready),
  .out_inverse        (result.inverse),
  .out_common_divisor (result.common_divisor),
  .out_has_inverse    (result.has_inverse)
);

`default_nettype wire
